// ----- hdl/cfr_pkg.sv -----
// Shared types, codes and helper functions for the clock frame replacement core.
// Used by the core, the port checker and the bench.
// No dependencies.
package cfr_pkg;

    localparam int FRAME_FIELD_W = 10;
    localparam int COUNT_FIELD_W = 7;
    localparam int FLAG_W        = 5;

    // Flag word layout kept in the table alongside the frame number.
    localparam int FL_ACC     = 0;
    localparam int FL_DIRTY   = 1;
    localparam int FL_PIN     = 2;
    localparam int FL_TYPE_LO = 3;
    localparam int FL_TYPE_HI = 4;

    localparam logic [1:0] TYPE_FILE = 2'd1;
    localparam logic [1:0] TYPE_ANON = 2'd2;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_EVICT  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NO_VICTIM = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ACT_DROP       = 2'd0,
        ACT_WRITE_BACK = 2'd1,
        ACT_SWAP       = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

    typedef struct packed {
        mode_t                    mode;
        logic [FRAME_FIELD_W-1:0] frame;
        logic                     accessed;
        logic                     dirty;
        logic                     pinned;
        logic [1:0]               page_type;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic [FRAME_FIELD_W-1:0] victim_frame;
        action_t                  victim_action;
        logic [COUNT_FIELD_W-1:0] entry_count;
    } rsp_t;

    function automatic logic [FLAG_W-1:0] make_flags(input req_t r);
        return {r.page_type, r.pinned, r.dirty, r.accessed};
    endfunction

    // A dirty or anonymous victim must be saved: mapped files go back to their
    // file and everything else goes to swap. Anything else is simply dropped.
    function automatic action_t victim_action(input logic [FLAG_W-1:0] fl);
        logic [1:0] ty;
        ty = fl[FL_TYPE_HI:FL_TYPE_LO];
        if (fl[FL_DIRTY] || (ty == TYPE_ANON)) begin
            return (ty == TYPE_FILE) ? ACT_WRITE_BACK : ACT_SWAP;
        end
        return ACT_DROP;
    endfunction

endpackage

// ----- hdl/clock_frame_replacement_core.sv -----
// Clock (second-chance) frame replacement table. One request is handled at a
// time; req_stall stays high from acceptance until the response is loaded into
// the output register. Timing is set by the single read port of the table
// memory, which visits one entry per cycle. Insert writes the new entry at the
// end of the table. Remove and update search from position 0 for the frame,
// and a remove then closes the gap by moving the later entries down. Evict
// advances the hand over at most 2N + 1 positions (N entries), and closes the
// gap behind the victim in the same way. No clearing pass is needed after
// reset: only entries below the entry count are ever used.
// Depends on cfr_pkg and cfr_ram.
module clock_frame_replacement_core #(
    parameter int MAX_FRAMES = 64,
    parameter int FRAME_BITS = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  cfr_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output cfr_pkg::rsp_t rsp_data
);

    localparam int IDX_W   = $clog2(MAX_FRAMES);
    localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
    localparam int STEP_W  = CNT_W + 1;
    localparam int FLAG_W  = cfr_pkg::FLAG_W;
    localparam int ENTRY_W = FRAME_BITS + FLAG_W;

    cfr_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [IDX_W-1:0] hand_reg, hand_next;
    logic             hand_valid_reg, hand_valid_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    cfr_pkg::req_t    cmd_reg, cmd_next;

    cfr_pkg::status_t  status_reg, status_next;
    logic [FRAME_BITS-1:0] vframe_reg, vframe_next;
    cfr_pkg::action_t  vaction_reg, vaction_next;

    logic             rsp_valid_reg, rsp_valid_next;
    cfr_pkg::rsp_t    rsp_reg, rsp_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    logic [FRAME_BITS-1:0] ent_frame;
    logic [FLAG_W-1:0]     ent_flags;
    logic [FRAME_BITS-1:0] req_frame;
    logic [FRAME_BITS-1:0] cmd_frame;

    // Decisions shared by the next-state and datapath blocks.
    logic             adv_ok;
    logic [IDX_W-1:0] adv_idx;
    logic             hit;
    logic             search_more;
    logic             scan_pass;
    logic             scan_stop;
    logic [IDX_W-1:0] rm_idx;
    logic             rm_more;
    logic             shift_more;
    logic             rsp_free;
    logic [STEP_W-1:0] limit;

    cfr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_FRAMES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign ent_frame = rd_data[ENTRY_W-1:FLAG_W];
    assign ent_flags = rd_data[FLAG_W-1:0];
    assign req_frame = FRAME_BITS'(req_data.frame);
    assign cmd_frame = FRAME_BITS'(cmd_reg.frame);
    assign limit     = {used_reg, 1'b1};
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        // Hand advance with wrap; it gives up on an empty table or when the only
        // entry would be visited again.
        adv_ok  = 1'b1;
        adv_idx = '0;
        if (!hand_valid_reg)
        begin
            adv_ok = (used_reg != '0);
        end
        else if ((CNT_W'(hand_reg) + CNT_W'(1)) >= used_reg)
        begin
            adv_ok = (hand_reg != '0);
        end
        else
        begin
            adv_idx = hand_reg + IDX_W'(1);
        end

        hit         = (ent_frame == cmd_frame);
        search_more = (CNT_W'(ptr_reg) + CNT_W'(1)) < used_reg;
        scan_pass   = ent_flags[cfr_pkg::FL_PIN] || ent_flags[cfr_pkg::FL_ACC];
        scan_stop   = (steps_reg >= limit) || !adv_ok;

        rm_idx  = (state_reg == cfr_pkg::ST_SCAN) ? hand_reg : ptr_reg;
        rm_more = CNT_W'(rm_idx) < (used_reg - CNT_W'(1));
        // The entry count is already reduced while the gap is being closed.
        shift_more = (CNT_W'(ptr_reg) + CNT_W'(1)) < used_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfr_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_data.mode) inside
                        cfr_pkg::MODE_INSERT:
                            state_next = cfr_pkg::ST_DONE;
                        cfr_pkg::MODE_REMOVE, cfr_pkg::MODE_UPDATE:
                            state_next = (used_reg == '0) ? cfr_pkg::ST_DONE
                                                          : cfr_pkg::ST_SEARCH;
                        cfr_pkg::MODE_EVICT:
                            state_next = adv_ok ? cfr_pkg::ST_SCAN : cfr_pkg::ST_DONE;
                        default:
                            state_next = cfr_pkg::ST_DONE;
                    endcase
                end
            end
            cfr_pkg::ST_SEARCH:
            begin
                if (hit)
                begin
                    if ((cmd_reg.mode == cfr_pkg::MODE_REMOVE) && rm_more)
                    begin
                        state_next = cfr_pkg::ST_SHIFT;
                    end
                    else
                    begin
                        state_next = cfr_pkg::ST_DONE;
                    end
                end
                else if (!search_more)
                begin
                    state_next = cfr_pkg::ST_DONE;
                end
            end
            cfr_pkg::ST_SCAN:
            begin
                if (scan_pass)
                begin
                    if (scan_stop)
                    begin
                        state_next = cfr_pkg::ST_DONE;
                    end
                end
                else
                begin
                    state_next = rm_more ? cfr_pkg::ST_SHIFT : cfr_pkg::ST_DONE;
                end
            end
            cfr_pkg::ST_SHIFT:
            begin
                if (!shift_more)
                begin
                    state_next = cfr_pkg::ST_DONE;
                end
            end
            cfr_pkg::ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = cfr_pkg::ST_IDLE;
                end
            end
            default:
                state_next = cfr_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        used_next       = used_reg;
        hand_next       = hand_reg;
        hand_valid_next = hand_valid_reg;
        ptr_next        = ptr_reg;
        steps_next      = steps_reg;
        cmd_next        = cmd_reg;
        status_next     = status_reg;
        vframe_next     = vframe_reg;
        vaction_next    = vaction_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        wr_en           = 1'b0;
        wr_addr         = ptr_reg;
        wr_data         = rd_data;
        rd_addr         = '0;

        unique case (state_reg)
            cfr_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next     = req_data;
                    status_next  = cfr_pkg::STAT_DONE;
                    vframe_next  = '0;
                    vaction_next = cfr_pkg::ACT_DROP;
                    ptr_next     = '0;
                    unique case (req_data.mode) inside
                        cfr_pkg::MODE_INSERT:
                        begin
                            if (used_reg >= CNT_W'(MAX_FRAMES))
                            begin
                                status_next = cfr_pkg::STAT_FULL;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                wr_addr   = IDX_W'(used_reg);
                                wr_data   = {req_frame, cfr_pkg::make_flags(req_data)};
                                used_next = used_reg + CNT_W'(1);
                            end
                        end
                        cfr_pkg::MODE_REMOVE, cfr_pkg::MODE_UPDATE:
                        begin
                            if (used_reg == '0)
                            begin
                                status_next = cfr_pkg::STAT_NOT_FOUND;
                            end
                        end
                        cfr_pkg::MODE_EVICT:
                        begin
                            if (adv_ok)
                            begin
                                hand_next       = adv_idx;
                                hand_valid_next = 1'b1;
                                rd_addr         = adv_idx;
                                steps_next      = STEP_W'(1);
                            end
                            else
                            begin
                                status_next = cfr_pkg::STAT_NO_VICTIM;
                            end
                        end
                        default:
                            status_next = cfr_pkg::STAT_DONE;
                    endcase
                end
            end
            cfr_pkg::ST_SEARCH:
            begin
                if (hit)
                begin
                    if (cmd_reg.mode == cfr_pkg::MODE_UPDATE)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = ptr_reg;
                        wr_data = {ent_frame, cfr_pkg::make_flags(cmd_reg)};
                    end
                end
                else if (search_more)
                begin
                    ptr_next = ptr_reg + IDX_W'(1);
                    rd_addr  = ptr_reg + IDX_W'(1);
                end
                else
                begin
                    status_next = cfr_pkg::STAT_NOT_FOUND;
                end
            end
            cfr_pkg::ST_SCAN:
            begin
                if (scan_pass)
                begin
                    // Second chance: an unpinned entry loses its accessed bit.
                    if (!ent_flags[cfr_pkg::FL_PIN])
                    begin
                        wr_en   = 1'b1;
                        wr_addr = hand_reg;
                        wr_data = {ent_frame,
                                   ent_flags & ~(FLAG_W'(1) << cfr_pkg::FL_ACC)};
                    end
                    if (scan_stop)
                    begin
                        status_next = cfr_pkg::STAT_NO_VICTIM;
                    end
                    else
                    begin
                        hand_next  = adv_idx;
                        rd_addr    = adv_idx;
                        steps_next = steps_reg + STEP_W'(1);
                    end
                end
                else
                begin
                    vframe_next  = ent_frame;
                    vaction_next = cfr_pkg::victim_action(ent_flags);
                end
            end
            cfr_pkg::ST_SHIFT:
            begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg;
                wr_data  = rd_data;
                ptr_next = ptr_reg + IDX_W'(1);
                rd_addr  = ptr_reg + IDX_W'(2);
            end
            cfr_pkg::ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.status        = status_reg;
                    rsp_next.victim_frame  = cfr_pkg::FRAME_FIELD_W'(vframe_reg);
                    rsp_next.victim_action = vaction_reg;
                    rsp_next.entry_count   = cfr_pkg::COUNT_FIELD_W'(used_reg);
                end
            end
            default:
                status_next = status_reg;
        endcase

        // Removal of a found entry (remove request or evict victim): the count
        // drops now, the hand is repaired, and the gap is closed in ST_SHIFT.
        if (((state_reg == cfr_pkg::ST_SEARCH) && hit &&
             (cmd_reg.mode == cfr_pkg::MODE_REMOVE)) ||
            ((state_reg == cfr_pkg::ST_SCAN) && !scan_pass))
        begin
            used_next = used_reg - CNT_W'(1);
            ptr_next  = rm_idx;
            rd_addr   = rm_idx + IDX_W'(1);
            if (hand_valid_reg)
            begin
                if (hand_reg == rm_idx)
                begin
                    if (!rm_more)
                    begin
                        hand_valid_next = 1'b0;
                    end
                end
                else if (hand_reg > rm_idx)
                begin
                    hand_next = hand_reg - IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cfr_pkg::ST_IDLE;
            used_reg       <= '0;
            hand_reg       <= '0;
            hand_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            hand_reg       <= hand_next;
            hand_valid_reg <= hand_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        steps_reg   <= steps_next;
        cmd_reg     <= cmd_next;
        status_reg  <= status_next;
        vframe_reg  <= vframe_next;
        vaction_reg <= vaction_next;
        rsp_reg     <= rsp_next;
    end

    assign req_stall = (state_reg != cfr_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

// ----- hdl/cfr_ram.sv -----
// Generic single-write, single-read memory with a registered read port.
// Holds the frame table of the clock frame replacement core; no dependencies.
module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/cfr_checker.sv -----
// Port-level checks for the clock frame replacement core, bound to the top level.
// Depends on cfr_pkg and clock_frame_replacement_core.
module cfr_checker #(
    parameter int MAX_FRAMES = 64
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input cfr_pkg::rsp_t rsp_data
);

    // One request at a time: the core stalls right after taking a request.
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("core accepted a second request while busy");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("stalled response changed or vanished");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status == cfr_pkg::STAT_FULL) |->
        (rsp_data.entry_count == cfr_pkg::COUNT_FIELD_W'(MAX_FRAMES)))
        else $error("table full reported with a short table");

    a_no_victim_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status != cfr_pkg::STAT_DONE) |->
        (rsp_data.victim_frame == '0) && (rsp_data.victim_action == cfr_pkg::ACT_DROP))
        else $error("victim fields set on a failed request");

endmodule

bind clock_frame_replacement_core cfr_checker #(.MAX_FRAMES(MAX_FRAMES)) u_cfr_checker (.*);

// ----- bench/clock_frame_replacement_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the clock frame replacement core: a clocked driver
// and monitor with a table predictor checking every response in order.
// Depends on cfr_pkg and the clock_frame_replacement_core RTL.
module clock_frame_replacement_core_tb;

    localparam int MAX_FRAMES   = 64;
    localparam int FRAME_BITS   = 10;
    localparam int RANDOM_ITEMS = 1025;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int FW           = cfr_pkg::FRAME_FIELD_W;
    localparam int FLW          = cfr_pkg::FLAG_W;

    localparam logic [1:0] TYPE_EXEC  = 2'd0;
    localparam logic [1:0] TYPE_SPARE = 2'd3;

    typedef enum int {PH_FILL, PH_CHURN, PH_DRAIN} mix_t;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          req_valid = 1'b0;
    logic          req_stall;
    cfr_pkg::req_t req_data = '0;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    cfr_pkg::rsp_t rsp_data;

    clock_frame_replacement_core #(
        .MAX_FRAMES(MAX_FRAMES),
        .FRAME_BITS(FRAME_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_data (req_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_data (rsp_data)
    );

    always #10 clk = ~clk;

    // Predicted frame table.
    logic [FW-1:0]  tab_frame [MAX_FRAMES];
    logic [FLW-1:0] tab_flags [MAX_FRAMES];
    int unsigned    tab_used  = 0;
    int unsigned    hand_pos  = 0;
    bit             hand_live = 1'b0;

    cfr_pkg::req_t pending_reqs [$];
    cfr_pkg::rsp_t awaited_rsps [$];
    logic [FW-1:0] frame_pool [$];

    cfr_pkg::rsp_t want_rsp;
    logic        req_taken     = 1'b0;
    int          reqs_accepted = 0;
    int          held_cycles   = 0;
    int          fail_count    = 0;
    int          cycle_count   = 0;
    int unsigned peak_used     = 0;
    int          status_seen [4] = '{0, 0, 0, 0};

    int burst_left    = 1;
    int gap_left      = 0;
    int stall_tick    = 0;
    int stall_style   = 0;
    int hold_left     = 0;
    int holdoffs_done = 0;

    function automatic int unsigned find_frame(input logic [FW-1:0] f);
        int unsigned idx;
        idx = tab_used;
        for (int unsigned i = 0; i < tab_used; i++)
        begin
            if (tab_frame[i] == f && idx == tab_used)
                idx = i;
        end
        return idx;
    endfunction

    // Close the gap left by a removed entry; the hand stays on its frame unless it was on that entry.
    function automatic void drop_entry(input int unsigned idx);
        for (int unsigned j = idx; j + 1 < tab_used; j++)
        begin
            tab_frame[j] = tab_frame[j + 1];
            tab_flags[j] = tab_flags[j + 1];
        end
        tab_used--;
        if (hand_live)
        begin
            if (hand_pos == idx)
            begin
                if (idx >= tab_used)
                    hand_live = 1'b0;
            end
            else if (hand_pos > idx)
                hand_pos--;
        end
    endfunction

    // Returns 0 on an empty table or when the hand would come back round to a lone entry.
    function automatic bit move_hand();
        if (!hand_live)
        begin
            if (tab_used == 0)
                return 1'b0;
            hand_pos  = 0;
            hand_live = 1'b1;
            return 1'b1;
        end
        if (hand_pos + 1 >= tab_used)
        begin
            if (hand_pos == 0)
                return 1'b0;
            hand_pos = 0;
        end
        else
            hand_pos++;
        return 1'b1;
    endfunction

    function automatic cfr_pkg::rsp_t run_command(input cfr_pkg::req_t r);
        cfr_pkg::rsp_t  o;
        int unsigned    idx;
        int unsigned    limit;
        int unsigned    steps;
        bit             found;
        bit             quit;
        logic [FLW-1:0] fl;
        logic [FLW-1:0] nf;
        logic [1:0]     ty;
        o = '0;
        nf = '0;
        nf[cfr_pkg::FL_ACC]   = r.accessed;
        nf[cfr_pkg::FL_DIRTY] = r.dirty;
        nf[cfr_pkg::FL_PIN]   = r.pinned;
        nf[cfr_pkg::FL_TYPE_HI:cfr_pkg::FL_TYPE_LO] = r.page_type;
        case (r.mode)
            cfr_pkg::MODE_INSERT:
            begin
                if (tab_used >= MAX_FRAMES)
                    o.status = cfr_pkg::STAT_FULL;
                else
                begin
                    tab_frame[tab_used] = r.frame;
                    tab_flags[tab_used] = nf;
                    tab_used++;
                end
            end
            cfr_pkg::MODE_REMOVE:
            begin
                idx = find_frame(r.frame);
                if (idx >= tab_used)
                    o.status = cfr_pkg::STAT_NOT_FOUND;
                else
                    drop_entry(idx);
            end
            cfr_pkg::MODE_UPDATE:
            begin
                idx = find_frame(r.frame);
                if (idx >= tab_used)
                    o.status = cfr_pkg::STAT_NOT_FOUND;
                else
                    tab_flags[idx] = nf;
            end
            default:
            begin
                limit = 2 * tab_used + 1;
                found = 1'b0;
                quit  = 1'b0;
                for (steps = 0; steps < limit && tab_used > 0 && !found && !quit; steps++)
                begin
                    if (!move_hand() || hand_pos >= tab_used)
                        quit = 1'b1;
                    else
                    begin
                        fl = tab_flags[hand_pos];
                        if (!fl[cfr_pkg::FL_PIN])
                        begin
                            if (fl[cfr_pkg::FL_ACC])
                                tab_flags[hand_pos][cfr_pkg::FL_ACC] = 1'b0;
                            else
                            begin
                                ty = fl[cfr_pkg::FL_TYPE_HI:cfr_pkg::FL_TYPE_LO];
                                o.victim_frame = tab_frame[hand_pos];
                                if (fl[cfr_pkg::FL_DIRTY] || ty == cfr_pkg::TYPE_ANON)
                                    o.victim_action = (ty == cfr_pkg::TYPE_FILE)
                                                      ? cfr_pkg::ACT_WRITE_BACK
                                                      : cfr_pkg::ACT_SWAP;
                                else
                                    o.victim_action = cfr_pkg::ACT_DROP;
                                drop_entry(hand_pos);
                                found = 1'b1;
                            end
                        end
                    end
                end
                if (!found)
                    o.status = cfr_pkg::STAT_NO_VICTIM;
            end
        endcase
        o.entry_count = cfr_pkg::COUNT_FIELD_W'(tab_used);
        if (tab_used > peak_used)
            peak_used = tab_used;
        return o;
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
            note_failure($sformatf("%s: expected %0d, got %0d", name, want, got));
    endtask

    task automatic push_cmd(input cfr_pkg::mode_t m, input logic [FW-1:0] f,
                            input logic a, input logic d, input logic p,
                            input logic [1:0] t);
        cfr_pkg::req_t r;
        r.mode      = m;
        r.frame     = f;
        r.accessed  = a;
        r.dirty     = d;
        r.pinned    = p;
        r.page_type = t;
        pending_reqs.push_back(r);
    endtask

    // Small frame numbers come up often so that duplicates are common.
    function automatic logic [FW-1:0] fresh_frame();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        if (roll < 7)
            return FW'($urandom_range(0, 15));
        return FW'($urandom_range(0, 1023));
    endfunction

    task automatic push_random(input mix_t mix);
        int              roll;
        int              pick;
        cfr_pkg::mode_t  m;
        logic [FW-1:0]   f;
        roll = $urandom_range(0, 99);
        case (mix)
            PH_FILL:
                m = roll < 85 ? cfr_pkg::MODE_INSERT : roll < 92 ? cfr_pkg::MODE_UPDATE :
                    roll < 96 ? cfr_pkg::MODE_REMOVE : cfr_pkg::MODE_EVICT;
            PH_CHURN:
                m = roll < 35 ? cfr_pkg::MODE_INSERT : roll < 50 ? cfr_pkg::MODE_REMOVE :
                    roll < 70 ? cfr_pkg::MODE_UPDATE : cfr_pkg::MODE_EVICT;
            default:
                m = roll < 5 ? cfr_pkg::MODE_INSERT : roll < 25 ? cfr_pkg::MODE_REMOVE :
                    roll < 35 ? cfr_pkg::MODE_UPDATE : cfr_pkg::MODE_EVICT;
        endcase
        f = fresh_frame();
        // Removes and updates mostly name a frame that was inserted earlier.
        if ((m == cfr_pkg::MODE_REMOVE || m == cfr_pkg::MODE_UPDATE) &&
            frame_pool.size() != 0 && $urandom_range(0, 4) != 0)
        begin
            pick = $urandom_range(0, frame_pool.size() - 1);
            f = frame_pool[pick];
            if (m == cfr_pkg::MODE_REMOVE)
                frame_pool.delete(pick);
        end
        if (m == cfr_pkg::MODE_INSERT)
        begin
            frame_pool.push_back(f);
            if (frame_pool.size() > MAX_FRAMES)
                frame_pool.delete(0);
        end
        push_cmd(m, f, $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1,
                 $urandom_range(0, 7) == 0, 2'($urandom_range(0, 3)));
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_taken)
        begin
            if (gap_left > 0 || pending_reqs.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                req_valid <= 1'b0;
            end
            else
            begin
                req_data  <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 9)) inside
                        [0:2]:   gap_left = 0;
                        9:       gap_left = $urandom_range(20, 150);
                        default: gap_left = $urandom_range(1, 8);
                    endcase
                end
            end
        end
    end

    // Response stall pattern, with two long hold-offs that back the core up.
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            stall_tick++;
            if (stall_tick % 256 == 0)
                stall_style = $urandom_range(0, 3);
            if (hold_left == 0 && holdoffs_done < 2 &&
                reqs_accepted >= 350 * (holdoffs_done + 1))
            begin
                hold_left = HOLD_CYCLES;
                holdoffs_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                case (stall_style)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= ($urandom_range(0, 2) == 0);
                    2:       rsp_stall <= ((stall_tick % 5) < 2);
                    default: rsp_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Monitor: checks responses against the oldest prediction, then predicts
    // the response for any request taken at this edge.
    always @(posedge clk)
    begin
        if (!rst_n)
            req_taken <= 1'b0;
        else
        begin
            req_taken <= req_valid && !req_stall;
            if (req_valid && req_stall)
                held_cycles++;
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_rsps.size() == 0)
                    note_failure("response arrived with no request outstanding");
                else
                begin
                    want_rsp = awaited_rsps.pop_front();
                    check_field("status", want_rsp.status, rsp_data.status);
                    check_field("victim_frame", want_rsp.victim_frame,
                                rsp_data.victim_frame);
                    check_field("victim_action", want_rsp.victim_action,
                                rsp_data.victim_action);
                    check_field("entry_count", want_rsp.entry_count,
                                rsp_data.entry_count);
                end
            end
            if (req_valid && !req_stall)
            begin
                want_rsp = run_command(req_data);
                status_seen[want_rsp.status]++;
                awaited_rsps.push_back(want_rsp);
                reqs_accepted++;
            end
        end
    end

    always @(posedge clk)
        cycle_count++;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles.", cycle_count);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int made;
        rst_n = 1'b0;

        // Empty table, then a lone entry evicted, then a lone pinned entry.
        push_cmd(cfr_pkg::MODE_EVICT,  10'd0,    1'b0, 1'b0, 1'b0, TYPE_EXEC);
        push_cmd(cfr_pkg::MODE_REMOVE, 10'd5,    1'b0, 1'b0, 1'b0, TYPE_EXEC);
        push_cmd(cfr_pkg::MODE_UPDATE, 10'd7,    1'b1, 1'b1, 1'b1, cfr_pkg::TYPE_ANON);
        push_cmd(cfr_pkg::MODE_INSERT, 10'd0,    1'b0, 1'b0, 1'b0, TYPE_EXEC);
        push_cmd(cfr_pkg::MODE_EVICT,  10'd0,    1'b0, 1'b0, 1'b0, TYPE_EXEC);
        push_cmd(cfr_pkg::MODE_INSERT, 10'd1023, 1'b1, 1'b1, 1'b1, TYPE_SPARE);
        push_cmd(cfr_pkg::MODE_EVICT,  10'd0,    1'b0, 1'b0, 1'b0, TYPE_EXEC);
        push_cmd(cfr_pkg::MODE_UPDATE, 10'd1023, 1'b0, 1'b1, 1'b0, TYPE_SPARE);
        push_cmd(cfr_pkg::MODE_INSERT, 10'd512,  1'b0, 1'b0, 1'b0, cfr_pkg::TYPE_FILE);
        push_cmd(cfr_pkg::MODE_EVICT,  10'd0,    1'b0, 1'b0, 1'b0, TYPE_EXEC);
        push_cmd(cfr_pkg::MODE_EVICT,  10'd0,    1'b0, 1'b0, 1'b0, TYPE_EXEC);
        // Duplicates: remove and update must hit the oldest copy.
        push_cmd(cfr_pkg::MODE_INSERT, 10'd100,  1'b0, 1'b1, 1'b0, cfr_pkg::TYPE_FILE);
        push_cmd(cfr_pkg::MODE_INSERT, 10'd100,  1'b1, 1'b0, 1'b0, cfr_pkg::TYPE_ANON);
        push_cmd(cfr_pkg::MODE_INSERT, 10'd200,  1'b0, 1'b0, 1'b0, cfr_pkg::TYPE_ANON);
        push_cmd(cfr_pkg::MODE_INSERT, 10'd300,  1'b0, 1'b0, 1'b1, TYPE_EXEC);
        push_cmd(cfr_pkg::MODE_UPDATE, 10'd100,  1'b0, 1'b1, 1'b0, cfr_pkg::TYPE_FILE);
        push_cmd(cfr_pkg::MODE_REMOVE, 10'd100,  1'b0, 1'b0, 1'b0, TYPE_EXEC);
        push_cmd(cfr_pkg::MODE_EVICT,  10'd0,    1'b0, 1'b0, 1'b0, TYPE_EXEC);
        push_cmd(cfr_pkg::MODE_EVICT,  10'd0,    1'b0, 1'b0, 1'b0, TYPE_EXEC);
        push_cmd(cfr_pkg::MODE_REMOVE, 10'd300,  1'b0, 1'b0, 1'b0, TYPE_EXEC);
        push_cmd(cfr_pkg::MODE_INSERT, 10'd5,    1'b0, 1'b0, 1'b0, TYPE_SPARE);
        push_cmd(cfr_pkg::MODE_EVICT,  10'd0,    1'b0, 1'b0, 1'b0, TYPE_EXEC);
        // Everything pinned: the scan runs out without a victim.
        push_cmd(cfr_pkg::MODE_INSERT, 10'd6,    1'b1, 1'b0, 1'b1, cfr_pkg::TYPE_ANON);
        push_cmd(cfr_pkg::MODE_INSERT, 10'd7,    1'b0, 1'b1, 1'b1, cfr_pkg::TYPE_FILE);
        push_cmd(cfr_pkg::MODE_EVICT,  10'd0,    1'b0, 1'b0, 1'b0, TYPE_EXEC);

        // Rounds of filling past full, mixed traffic, then draining.
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            for (int i = 0; i < 300 && made < RANDOM_ITEMS; i++)
            begin
                push_random(i < 90 ? PH_FILL : i < 210 ? PH_CHURN : PH_DRAIN);
                made++;
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_valid)
            @(negedge clk);
        while (awaited_rsps.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d requests: %0d done, %0d not found, %0d full, %0d with no victim.",
                 reqs_accepted, status_seen[cfr_pkg::STAT_DONE],
                 status_seen[cfr_pkg::STAT_NOT_FOUND], status_seen[cfr_pkg::STAT_FULL],
                 status_seen[cfr_pkg::STAT_NO_VICTIM]);
        $display("Table peak %0d entries; requests held off %0d cycles; %0d faults.",
                 peak_used, held_cycles, fail_count);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- clock_frame_replacement_core.f -----
hdl/cfr_pkg.sv
hdl/cfr_ram.sv
hdl/clock_frame_replacement_core.sv
hdl/cfr_checker.sv
bench/clock_frame_replacement_core_tb.sv
